FILE: hw/rtl/wamm_pkg.sv
// ============================================================================
// wamm_pkg - shared types and constants of the window average/min/max core
// Holds default sizes, the register layout and the divider status word.
// ============================================================================
package wamm_pkg;

    // Default sizes handed to the top level parameters
    localparam int WINDOW_MAX_DEF  = 256;
    localparam int SAMPLE_BITS_DEF = 16;

    // Window length register
    localparam int              LEN_CFG_BITS = 9;
    localparam logic [8:0]      LEN_RESET    = 9'd16;

    // Word layout
    localparam int AXES            = 3;
    localparam int FIELDS_PER_AXIS = 4;
    localparam int FLD_ECHO        = 0;
    localparam int FLD_MEAN        = 1;
    localparam int FLD_PEAK        = 2;
    localparam int FLD_FLOOR       = 3;

    // Status of one divider lane
    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

    // Clamp the programmed length into 1 .. wmax
    function automatic logic [31:0] eff_length(input logic [LEN_CFG_BITS-1:0] v,
                                               input int unsigned wmax);
        logic [31:0] v32;
        v32 = {{(32-LEN_CFG_BITS){1'b0}}, v};
        if (v32 == 32'd0) begin
            return 32'd1;
        end else if (v32 > wmax) begin
            return wmax;
        end else begin
            return v32;
        end
    endfunction

endpackage

FILE: hw/rtl/window_average_min_max_core.sv
// ============================================================================
// window_average_min_max_core - sliding window mean, max and min, three axes
// A word that only fills the window goes from accept through ST_READ back to ready.
// A word with a result loads the result register once the history scan through
// the one memory read port and the bit-serial divider lanes have both finished;
// ready rises at that same edge.
// A result still waiting on m_tready holds the load back by the stall length.
// Reset (synchronous, aresetn low): length 16, empty window, sums zero, no result.
// ============================================================================
module window_average_min_max_core #(
    parameter int WINDOW_MAX  = wamm_pkg::WINDOW_MAX_DEF,
    parameter int SAMPLE_BITS = wamm_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                         aclk,
    input  logic                                         aresetn,
    // window length register
    input  logic                                         cfg_wr_en,
    input  logic [wamm_pkg::LEN_CFG_BITS-1:0]            cfg_wr_data,
    // sample stream
    input  logic                                         s_tvalid,
    output logic                                         s_tready,
    // fields from bit 0: sample_x, sample_y, sample_z, zero fill
    input  logic [((3*SAMPLE_BITS+7)/8)*8-1:0]           s_tdata,
    // result stream
    output logic                                         m_tvalid,
    input  logic                                         m_tready,
    // fields from bit 0: echo_x, mean_x, peak_x, floor_x, echo_y, mean_y,
    // peak_y, floor_y, echo_z, mean_z, peak_z, floor_z, zero fill
    output logic [((12*SAMPLE_BITS+7)/8)*8-1:0]          m_tdata
);

    localparam int AXES      = wamm_pkg::AXES;
    localparam int FPA       = wamm_pkg::FIELDS_PER_AXIS;
    localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
    localparam int ADDR_BITS = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
    localparam int SUM_BITS  = SAMPLE_BITS + $clog2(WINDOW_MAX);
    localparam int WORD_BITS = AXES * SAMPLE_BITS;
    localparam int M_BITS    = ((AXES*FPA*SAMPLE_BITS+7)/8)*8;

    // One-hot control states
    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,   // wait for a sample word
        ST_READ = 3'b010,   // oldest entry arrives; update sums, write back
        ST_SCAN = 3'b100    // sweep the window, wait for the dividers
    } state_t;

    state_t state_reg, state_next;

    // Window bookkeeping
    logic [CNT_BITS-1:0]  len_reg;
    logic [CNT_BITS-1:0]  fill_reg;
    logic [ADDR_BITS-1:0] slot_reg;
    logic signed [SUM_BITS-1:0]    sum_reg  [AXES];
    logic signed [SUM_BITS-1:0]    sum_next [AXES];
    logic signed [SAMPLE_BITS-1:0] samp_reg [AXES];

    // History memory: one entry holds all three axes
    logic [WORD_BITS-1:0] hist_mem [WINDOW_MAX];
    logic [WORD_BITS-1:0] rd_data_reg;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 mem_we;
    logic [WORD_BITS-1:0] wr_word;

    // Scan pipeline
    logic [CNT_BITS-1:0]  idx_reg;
    logic                 rv_reg;
    logic                 first_reg;
    logic                 issue;
    logic                 scan_done;
    logic signed [SAMPLE_BITS-1:0] peak_reg  [AXES];
    logic signed [SAMPLE_BITS-1:0] floor_reg [AXES];
    logic signed [SAMPLE_BITS-1:0] cur       [AXES];

    // Dividers
    logic                          div_start;
    logic signed [SAMPLE_BITS-1:0] mean [AXES];
    wamm_pkg::div_stat_t           div_stat [AXES];
    logic                          divs_done;

    // Output register
    logic              m_valid_reg;
    logic [M_BITS-1:0] m_data_reg;
    logic [M_BITS-1:0] result_word;
    logic              out_load;

    logic accept;
    logic full;
    logic slot_wrap;

    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign full      = (fill_reg >= len_reg);
    assign slot_wrap = ({{(CNT_BITS-ADDR_BITS){1'b0}}, slot_reg} + 1'b1 >= {1'b0, len_reg});

    // Scan issues one address per cycle until the whole window is read
    assign issue     = (idx_reg < len_reg);
    assign scan_done = !issue && !rv_reg;

    always_comb begin
        divs_done = 1'b1;
        for (int a = 0; a < AXES; a++) begin
            divs_done = divs_done && div_stat[a].done && !div_stat[a].busy;
        end
    end

    assign out_load  = (state_reg == ST_SCAN) && scan_done && divs_done
                       && (!m_valid_reg || m_tready);
    assign div_start = (state_reg == ST_READ) && full;
    assign mem_we    = (state_reg == ST_READ);

    // Read address: oldest slot on accept, sweep index while scanning
    always_comb begin
        if (state_reg == ST_SCAN) begin
            rd_addr = idx_reg[ADDR_BITS-1:0];
        end else begin
            rd_addr = slot_reg;
        end
    end

    // Sum update: drop the oldest sample once full, add the new one
    always_comb begin
        for (int a = 0; a < AXES; a++) begin
            cur[a]      = $signed(rd_data_reg[a*SAMPLE_BITS +: SAMPLE_BITS]);
            sum_next[a] = sum_reg[a] + SUM_BITS'(samp_reg[a])
                          - (full ? SUM_BITS'(cur[a]) : SUM_BITS'(0));
            wr_word[a*SAMPLE_BITS +: SAMPLE_BITS] = samp_reg[a];
        end
    end

    // Pack the result word, echo field in the lowest bits of each axis
    always_comb begin
        result_word = '0;
        for (int a = 0; a < AXES; a++) begin
            result_word[(a*FPA+wamm_pkg::FLD_ECHO)*SAMPLE_BITS +: SAMPLE_BITS]  = samp_reg[a];
            result_word[(a*FPA+wamm_pkg::FLD_MEAN)*SAMPLE_BITS +: SAMPLE_BITS]  = mean[a];
            result_word[(a*FPA+wamm_pkg::FLD_PEAK)*SAMPLE_BITS +: SAMPLE_BITS]  = peak_reg[a];
            result_word[(a*FPA+wamm_pkg::FLD_FLOOR)*SAMPLE_BITS +: SAMPLE_BITS] = floor_reg[a];
        end
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    state_next = ST_READ;
                end
            end
            ST_READ: begin
                state_next = full ? ST_SCAN : ST_IDLE;
            end
            ST_SCAN: begin
                if (out_load) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // History memory: write back the new word, registered read
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            hist_mem[slot_reg] <= wr_word;
        end
        rd_data_reg <= hist_mem[rd_addr];
    end

    // Control and window state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            len_reg     <= CNT_BITS'(wamm_pkg::eff_length(wamm_pkg::LEN_RESET, WINDOW_MAX));
            fill_reg    <= '0;
            slot_reg    <= '0;
            m_valid_reg <= 1'b0;
            rv_reg      <= 1'b0;
            idx_reg     <= '0;
            first_reg   <= 1'b0;
            for (int a = 0; a < AXES; a++) begin
                sum_reg[a] <= '0;
            end
        end else begin
            state_reg <= state_next;

            // new length: restart the fill
            if (cfg_wr_en) begin
                len_reg  <= CNT_BITS'(wamm_pkg::eff_length(cfg_wr_data, WINDOW_MAX));
                fill_reg <= '0;
                slot_reg <= '0;
                for (int a = 0; a < AXES; a++) begin
                    sum_reg[a] <= '0;
                end
            end

            // hand off the result
            if (out_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            if (state_reg == ST_READ) begin
                for (int a = 0; a < AXES; a++) begin
                    sum_reg[a] <= sum_next[a];
                end
                slot_reg  <= slot_wrap ? '0 : slot_reg + 1'b1;
                if (!full) begin
                    fill_reg <= fill_reg + 1'b1;
                end
                idx_reg   <= '0;
                rv_reg    <= 1'b0;
                first_reg <= 1'b1;
            end

            if (state_reg == ST_SCAN) begin
                rv_reg <= issue;
                if (issue) begin
                    idx_reg <= idx_reg + 1'b1;
                end
                if (rv_reg) begin
                    first_reg <= 1'b0;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int a = 0; a < AXES; a++) begin
                samp_reg[a] <= $signed(s_tdata[a*SAMPLE_BITS +: SAMPLE_BITS]);
            end
        end
        // track extremes as the swept entries come back
        if ((state_reg == ST_SCAN) && rv_reg) begin
            for (int a = 0; a < AXES; a++) begin
                if (first_reg || (cur[a] > peak_reg[a])) begin
                    peak_reg[a] <= cur[a];
                end
                if (first_reg || (cur[a] < floor_reg[a])) begin
                    floor_reg[a] <= cur[a];
                end
            end
        end
        if (out_load) begin
            m_data_reg <= result_word;
        end
    end

    // One divider lane per axis, started with the updated sum
    for (genvar a = 0; a < AXES; a++) begin : g_div
        wamm_div #(
            .SUM_BITS (SUM_BITS),
            .LEN_BITS (CNT_BITS),
            .OUT_BITS (SAMPLE_BITS)
        ) u_div (
            .aclk     (aclk),
            .aresetn  (aresetn),
            .start    (div_start),
            .dividend (sum_next[a]),
            .divisor  (len_reg),
            .quotient (mean[a]),
            .stat     (div_stat[a])
        );
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

FILE: hw/rtl/wamm_div.sv
// ============================================================================
// wamm_div - iterative signed-by-unsigned divider
// Restoring division, one quotient bit per cycle, truncates toward zero.
// ============================================================================
module wamm_div #(
    parameter int SUM_BITS = 24,
    parameter int LEN_BITS = 9,
    parameter int OUT_BITS = 16
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic signed [SUM_BITS-1:0]  dividend,
    input  logic        [LEN_BITS-1:0]  divisor,
    output logic signed [OUT_BITS-1:0]  quotient,
    output wamm_pkg::div_stat_t         stat
);

    localparam int CNT_W = $clog2(SUM_BITS + 1);

    logic [CNT_W-1:0]    cnt_reg;
    logic                busy_reg;
    logic                done_reg;
    logic                neg_reg;
    logic [LEN_BITS-1:0] rem_reg;
    logic [LEN_BITS-1:0] div_reg;
    logic [SUM_BITS-1:0] quo_reg;

    logic [LEN_BITS:0]   trial;
    logic [LEN_BITS:0]   diff;
    logic                ge;
    logic [LEN_BITS-1:0] rem_next;
    logic [SUM_BITS-1:0] mag;
    logic [SUM_BITS-1:0] signed_quo;

    always_comb begin
        trial    = {rem_reg, quo_reg[SUM_BITS-1]};
        diff     = trial - {1'b0, div_reg};
        ge       = (trial >= {1'b0, div_reg});
        rem_next = ge ? diff[LEN_BITS-1:0] : trial[LEN_BITS-1:0];
        mag      = dividend[SUM_BITS-1] ? (~$unsigned(dividend) + 1'b1) : $unsigned(dividend);
        signed_quo = neg_reg ? (~quo_reg + 1'b1) : quo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            neg_reg  <= dividend[SUM_BITS-1];
            rem_reg  <= '0;
            div_reg  <= divisor;
            quo_reg  <= mag;
        end else if (busy_reg) begin
            rem_reg <= rem_next;
            quo_reg <= {quo_reg[SUM_BITS-2:0], ge};
            cnt_reg <= cnt_reg + 1'b1;
            // last quotient bit: finish
            if (cnt_reg == CNT_W'(SUM_BITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign quotient  = signed_quo[OUT_BITS-1:0];
    assign stat.busy = busy_reg;
    assign stat.done = done_reg;

endmodule
